// File: rtl/core/morse_code_keyer_unit_macros.svh
// ---------------------------------------------------------------------------
// Morse keyer assertion macros
// Shared helpers for the concurrent checks in the keyer RTL.
// ---------------------------------------------------------------------------
`ifndef MORSE_CODE_KEYER_UNIT_MACROS_SVH
`define MORSE_CODE_KEYER_UNIT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MCK_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define MCK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/mck_pkg.sv
// ---------------------------------------------------------------------------
// Morse keyer package
// Shared types, constants and the letter code table of the keyer.
// ---------------------------------------------------------------------------
package mck_pkg;

   localparam logic [1:0] KIND_LETTER  = 2'd0;
   localparam logic [1:0] KIND_SPACE   = 2'd1;
   localparam logic [1:0] KIND_INVALID = 2'd2;

   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

   localparam logic [2:0] DOT_UNITS        = 3'd1;
   localparam logic [2:0] DASH_UNITS       = 3'd3;
   localparam logic [2:0] GAP_UNITS        = 3'd1;
   localparam logic [2:0] LETTER_END_UNITS = 3'd3;
   localparam logic [2:0] WORD_UNITS       = 3'd7;
   localparam logic [2:0] NO_UNITS         = 3'd0;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Bit e of pattern is set when element e of the letter is a dash.
   typedef struct packed {
      logic [2:0] len;
      logic [3:0] pattern;
   } code_type;

   typedef struct packed {
      logic [1:0] kind;
      code_type   code;
   } item_type;

   function automatic code_type letter_code(input logic [4:0] idx);
      code_type c;
      unique case (idx)
         5'd0:    c = '{len: 3'd2, pattern: 4'b0010};
         5'd1:    c = '{len: 3'd4, pattern: 4'b0001};
         5'd2:    c = '{len: 3'd4, pattern: 4'b0101};
         5'd3:    c = '{len: 3'd3, pattern: 4'b0001};
         5'd4:    c = '{len: 3'd1, pattern: 4'b0000};
         5'd5:    c = '{len: 3'd4, pattern: 4'b0100};
         5'd6:    c = '{len: 3'd3, pattern: 4'b0011};
         5'd7:    c = '{len: 3'd4, pattern: 4'b0000};
         5'd8:    c = '{len: 3'd2, pattern: 4'b0000};
         5'd9:    c = '{len: 3'd4, pattern: 4'b1110};
         5'd10:   c = '{len: 3'd3, pattern: 4'b0101};
         5'd11:   c = '{len: 3'd4, pattern: 4'b0010};
         5'd12:   c = '{len: 3'd2, pattern: 4'b0011};
         5'd13:   c = '{len: 3'd2, pattern: 4'b0001};
         5'd14:   c = '{len: 3'd3, pattern: 4'b0111};
         5'd15:   c = '{len: 3'd4, pattern: 4'b0110};
         5'd16:   c = '{len: 3'd4, pattern: 4'b1011};
         5'd17:   c = '{len: 3'd3, pattern: 4'b0010};
         5'd18:   c = '{len: 3'd3, pattern: 4'b0000};
         5'd19:   c = '{len: 3'd1, pattern: 4'b0001};
         5'd20:   c = '{len: 3'd3, pattern: 4'b0100};
         5'd21:   c = '{len: 3'd4, pattern: 4'b1000};
         5'd22:   c = '{len: 3'd3, pattern: 4'b0110};
         5'd23:   c = '{len: 3'd4, pattern: 4'b1001};
         5'd24:   c = '{len: 3'd4, pattern: 4'b1101};
         5'd25:   c = '{len: 3'd4, pattern: 4'b0011};
         default: c = '{len: 3'd1, pattern: 4'b0000};
      endcase
      return c;
   endfunction

endpackage

// File: rtl/core/mck_front.sv
// ---------------------------------------------------------------------------
// Morse keyer front end
// Accepts characters, classifies them and looks up the letter code.
// ---------------------------------------------------------------------------
module mck_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,
   output logic              push_valid,
   input  logic              push_ready,
   output mck_pkg::item_type push_item
);

   logic              stage_valid_ff;
   logic              stage_valid_in;
   mck_pkg::item_type stage_item_ff;
   mck_pkg::item_type stage_item_in;
   logic              accept;

   assign req_tready = !stage_valid_ff || push_ready;
   assign accept     = req_tvalid && req_tready;
   assign push_valid = stage_valid_ff;
   assign push_item  = stage_item_ff;

   always_comb begin
      logic is_upper;
      logic is_lower;
      is_upper = (req_tdata >= mck_pkg::CHAR_UPPER_A) && (req_tdata <= mck_pkg::CHAR_UPPER_Z);
      is_lower = (req_tdata >= mck_pkg::CHAR_LOWER_A) && (req_tdata <= mck_pkg::CHAR_LOWER_Z);
      stage_item_in.code = mck_pkg::letter_code(req_tdata[4:0] - 5'd1);
      priority if (req_tdata == mck_pkg::CHAR_SPACE) begin
         stage_item_in.kind = mck_pkg::KIND_SPACE;
      end else if (is_upper || is_lower) begin
         stage_item_in.kind = mck_pkg::KIND_LETTER;
      end else begin
         stage_item_in.kind = mck_pkg::KIND_INVALID;
      end
   end

   always_comb begin
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (push_ready) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_item_ff <= stage_item_in;
      end
   end

endmodule

// File: rtl/core/mck_queue.sv
// ---------------------------------------------------------------------------
// Morse keyer item queue
// Short first-in first-out buffer between the front end and the sequencer.
// ---------------------------------------------------------------------------
module mck_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  mck_pkg::item_type push_item,
   output logic              pop_valid,
   input  logic              pop_ready,
   output mck_pkg::item_type pop_item
);

   mck_pkg::item_type          entries_ff [mck_pkg::QUEUE_DEPTH];
   logic [mck_pkg::QPTR_W-1:0] wr_ptr_ff;
   logic [mck_pkg::QPTR_W-1:0] wr_ptr_in;
   logic [mck_pkg::QPTR_W-1:0] rd_ptr_ff;
   logic [mck_pkg::QPTR_W-1:0] rd_ptr_in;
   logic [mck_pkg::QCNT_W-1:0] count_ff;
   logic [mck_pkg::QCNT_W-1:0] count_in;
   logic                       do_push;
   logic                       do_pop;

   localparam logic [mck_pkg::QPTR_W-1:0] LAST_PTR = mck_pkg::QPTR_W'(mck_pkg::QUEUE_DEPTH - 1);
   localparam logic [mck_pkg::QCNT_W-1:0] FULL_CNT = mck_pkg::QCNT_W'(mck_pkg::QUEUE_DEPTH);

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/core/mck_back.sv
// ---------------------------------------------------------------------------
// Morse keyer sequencer
// Steps through the keying segments of one item and registers each result.
// ---------------------------------------------------------------------------
`include "morse_code_keyer_unit_macros.svh"

module mck_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  mck_pkg::item_type pop_item,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,
   output logic              rsp_tuser,
   output logic              rsp_tlast
);

   mck_pkg::item_type cur_item_ff;
   logic              cur_valid_ff;
   logic              cur_valid_in;
   logic [3:0]        seg_ff;
   logic [3:0]        seg_in;
   logic              out_valid_ff;
   logic              out_valid_in;
   logic              out_level_ff;
   logic [2:0]        out_units_ff;
   logic              out_invalid_ff;
   logic              out_last_ff;
   logic              advance;
   logic              seg_level;
   logic [2:0]        seg_units;
   logic              seg_invalid;
   logic              seg_last;
   logic [3:0]        letter_end;

   assign letter_end = {cur_item_ff.code.len, 1'b0};
   assign advance    = cur_valid_ff && (!out_valid_ff || rsp_tready);
   assign pop_ready  = !cur_valid_ff || (advance && seg_last);

   always_comb begin
      seg_level   = 1'b0;
      seg_units   = mck_pkg::NO_UNITS;
      seg_invalid = 1'b0;
      seg_last    = 1'b1;
      unique case (cur_item_ff.kind)
         mck_pkg::KIND_LETTER: begin
            if (seg_ff == letter_end) begin
               seg_units = mck_pkg::LETTER_END_UNITS;
            end else if (!seg_ff[0]) begin
               seg_level = 1'b1;
               seg_units = cur_item_ff.code.pattern[seg_ff[2:1]] ? mck_pkg::DASH_UNITS
                                                                  : mck_pkg::DOT_UNITS;
               seg_last  = 1'b0;
            end else begin
               seg_units = mck_pkg::GAP_UNITS;
               seg_last  = 1'b0;
            end
         end
         mck_pkg::KIND_SPACE: begin
            if (seg_ff == 4'd0) begin
               seg_units = mck_pkg::WORD_UNITS;
               seg_last  = 1'b0;
            end else begin
               seg_units = mck_pkg::LETTER_END_UNITS;
            end
         end
         default: begin
            seg_invalid = 1'b1;
         end
      endcase
   end

   always_comb begin
      cur_valid_in = cur_valid_ff;
      seg_in       = seg_ff;
      if (pop_ready) begin
         cur_valid_in = pop_valid;
         seg_in       = 4'd0;
      end else if (advance) begin
         seg_in = seg_ff + 4'd1;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         seg_ff       <= 4'd0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         seg_ff       <= seg_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_ready && pop_valid) begin
         cur_item_ff <= pop_item;
      end
      if (advance) begin
         out_level_ff   <= seg_level;
         out_units_ff   <= seg_units;
         out_invalid_ff <= seg_invalid;
         out_last_ff    <= seg_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_units_ff, out_level_ff};
   assign rsp_tuser  = out_invalid_ff;
   assign rsp_tlast  = out_last_ff;

   `MCK_ASSERT_SAME(a_seg_in_range, clock, reset,
      cur_valid_ff && (cur_item_ff.kind == mck_pkg::KIND_LETTER), seg_ff <= letter_end,
      "Segment counter ran past the end of the letter.")
   `MCK_ASSERT_SAME(a_invalid_is_single, clock, reset,
      out_valid_ff && out_invalid_ff, out_last_ff && (out_units_ff == mck_pkg::NO_UNITS),
      "Invalid result is not a single zero-length segment.")
   `MCK_ASSERT_NEXT(a_finish_clears_seg, clock, reset,
      advance && seg_last, seg_ff == 4'd0,
      "Segment counter did not restart after the final segment.")

endmodule

// File: rtl/core/morse_code_keyer_unit.sv
// ---------------------------------------------------------------------------
// Morse code keyer unit
// Turns ASCII characters into International Morse keying segments.
// ---------------------------------------------------------------------------
// Each request carries one character; each response is one keying segment
// with its line level and length in time units, with tlast on the final
// segment of the character. A letter gives 2n+1 segments for n elements (up
// to nine), a space gives two and any other code gives one segment flagged
// invalid in tuser. The sequencer emits one segment per cycle while the
// receiver is ready, so a character holds the response channel for one to
// nine segments and that sets the sustained rate; requests are taken every
// cycle while the two-entry item queue has room, and each character passes
// the front stage, the queue and the current-item register to the output.
module morse_code_keyer_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,  // [7:0] char_code
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,  // [0] level, [3:1] units, [7:4] zero
   output logic       rsp_tuser,  // [0] invalid
   output logic       rsp_tlast
);

   logic              push_valid;
   logic              push_ready;
   mck_pkg::item_type push_item;
   logic              pop_valid;
   logic              pop_ready;
   mck_pkg::item_type pop_item;

   mck_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   mck_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   mck_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: bench/testbench.sv
// ---------------------------------------------------------------------------
// Morse code keyer unit testbench
// Sends ASCII characters through the request stream and checks every keying
// segment on the response stream against an independent Morse predictor,
// with random idle cycles on both sides of the block.
// ---------------------------------------------------------------------------
module testbench;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int RANDOM_CHARS  = 450;
   localparam int DIRECTED_ROWS = 24;
   localparam int DRAIN_CYCLES  = 20;

   typedef struct packed {
      logic       level;
      logic [2:0] units;
      logic       invalid;
      logic       last;
   } segment_type;

   typedef struct packed {
      logic [7:0]        code;
      logic [1:0]        n_typed;
      segment_type [1:0] typed;
   } char_row_type;

   localparam segment_type SEG_BAD  =
      '{level: 1'b0, units: mck_pkg::NO_UNITS, invalid: 1'b1, last: 1'b1};
   localparam segment_type SEG_WORD =
      '{level: 1'b0, units: mck_pkg::WORD_UNITS, invalid: 1'b0, last: 1'b0};
   localparam segment_type SEG_END  =
      '{level: 1'b0, units: mck_pkg::LETTER_END_UNITS, invalid: 1'b0, last: 1'b1};
   localparam segment_type SEG_GAP  =
      '{level: 1'b0, units: mck_pkg::GAP_UNITS, invalid: 1'b0, last: 1'b0};
   localparam segment_type SEG_NONE = '0;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;  // [7:0] char_code
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;          // [0] level, [3:1] units, [7:4] zero
   logic       rsp_tuser;          // [0] invalid
   logic       rsp_tlast;

   string morse_letters [26] = '{
      ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
      "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
      "..-", "...-", ".--", "-..-", "-.--", "--.."
   };

   segment_type  keying_expected [$];
   char_row_type char_plan [$];
   char_row_type directed_table [DIRECTED_ROWS];
   int           cycle_count = 0;
   int           error_count = 0;
   int           chars_sent = 0;
   int           segments_seen = 0;
   int           invalid_seen = 0;
   bit           receiver_on = 1'b0;

   morse_code_keyer_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d segments outstanding.",
                  cycle_count, keying_expected.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic char_row_type row(input logic [7:0] code, input logic [1:0] n,
                                        input segment_type first,
                                        input segment_type second);
      char_row_type r;
      r.code    = code;
      r.n_typed = n;
      r.typed   = {second, first};
      return r;
   endfunction

   function automatic void queue_segment(input segment_type seg);
      keying_expected.insert(keying_expected.size(), seg);
   endfunction

   function automatic void plan_char(input char_row_type r);
      char_plan.insert(char_plan.size(), r);
   endfunction

   // Every third stretch of 32 draws has no idling at all.
   function automatic int idle_cycles(input int n);
      if (((n / 32) % 3) == 2)
         return 0;
      return $urandom_range(0, 19);
   endfunction

   function automatic void predict_keying(input logic [7:0] ch);
      string       code;
      int          idx;
      segment_type mark;
      if (ch == mck_pkg::CHAR_SPACE) begin
         queue_segment(SEG_WORD);
         queue_segment(SEG_END);
         return;
      end
      if (ch >= mck_pkg::CHAR_UPPER_A && ch <= mck_pkg::CHAR_UPPER_Z)
         idx = ch - mck_pkg::CHAR_UPPER_A;
      else if (ch >= mck_pkg::CHAR_LOWER_A && ch <= mck_pkg::CHAR_LOWER_Z)
         idx = ch - mck_pkg::CHAR_LOWER_A;
      else begin
         queue_segment(SEG_BAD);
         return;
      end
      code = morse_letters[idx];
      for (int e = 0; e < code.len(); e++) begin
         mark = '{level: 1'b1,
                  units: (code[e] == "-") ? mck_pkg::DASH_UNITS : mck_pkg::DOT_UNITS,
                  invalid: 1'b0, last: 1'b0};
         queue_segment(mark);
         queue_segment(SEG_GAP);
      end
      queue_segment(SEG_END);
   endfunction

   function automatic void report_failure(input string what, input segment_type exp,
                                          input segment_type got);
      if (error_count < 10)
         $display({"%s: expected level %0d units %0d invalid %0d last %0d, ",
                   "got level %0d units %0d invalid %0d last %0d"},
                  what, exp.level, exp.units, exp.invalid, exp.last,
                  got.level, got.units, got.invalid, got.last);
      error_count++;
   endfunction

   function automatic void check_segment(input segment_type got);
      segment_type exp;
      segments_seen++;
      if (got.invalid === 1'b1)
         invalid_seen++;
      if (keying_expected.size() == 0) begin
         report_failure("Unexpected segment", SEG_NONE, got);
         return;
      end
      exp = keying_expected.pop_front();
      if (got.level !== exp.level || got.units !== exp.units ||
          got.invalid !== exp.invalid || got.last !== exp.last)
         report_failure("Segment mismatch", exp, got);
   endfunction

   task automatic send_chars();
      int gap;
      for (int i = 0; i < char_plan.size(); i++) begin
         gap = idle_cycles(i);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= char_plan[i].code;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         chars_sent++;
         if (char_plan[i].n_typed == 0)
            predict_keying(char_plan[i].code);
         else
            for (int k = 0; k < char_plan[i].n_typed; k++)
               queue_segment(char_plan[i].typed[k]);
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin
      int stall;
      int n;
      n = 0;
      wait (receiver_on);
      forever begin
         stall = idle_cycles(n);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         check_segment('{level: rsp_tdata[0], units: rsp_tdata[3:1],
                         invalid: rsp_tuser, last: rsp_tlast});
         n++;
      end
   end

   initial begin
      int pick;
      directed_table = '{
         row(8'h00, 2'd1, SEG_BAD, SEG_NONE),
         row(8'hFF, 2'd1, SEG_BAD, SEG_NONE),
         row(mck_pkg::CHAR_SPACE, 2'd2, SEG_WORD, SEG_END),
         row(mck_pkg::CHAR_SPACE, 2'd2, SEG_WORD, SEG_END),
         row(mck_pkg::CHAR_UPPER_A, 2'd0, SEG_NONE, SEG_NONE),
         row(mck_pkg::CHAR_UPPER_Z, 2'd0, SEG_NONE, SEG_NONE),
         row(mck_pkg::CHAR_LOWER_A, 2'd0, SEG_NONE, SEG_NONE),
         row(mck_pkg::CHAR_LOWER_Z, 2'd0, SEG_NONE, SEG_NONE),
         row(mck_pkg::CHAR_UPPER_A - 8'd1, 2'd1, SEG_BAD, SEG_NONE),
         row(mck_pkg::CHAR_UPPER_Z + 8'd1, 2'd1, SEG_BAD, SEG_NONE),
         row(mck_pkg::CHAR_LOWER_A - 8'd1, 2'd1, SEG_BAD, SEG_NONE),
         row(mck_pkg::CHAR_LOWER_Z + 8'd1, 2'd1, SEG_BAD, SEG_NONE),
         row(8'h30, 2'd1, SEG_BAD, SEG_NONE),
         row(8'h80, 2'd1, SEG_BAD, SEG_NONE),
         row(8'h7F, 2'd1, SEG_BAD, SEG_NONE),
         row("E", 2'd0, SEG_NONE, SEG_NONE),
         row("T", 2'd0, SEG_NONE, SEG_NONE),
         row("B", 2'd0, SEG_NONE, SEG_NONE),
         row("Q", 2'd0, SEG_NONE, SEG_NONE),
         row("Y", 2'd0, SEG_NONE, SEG_NONE),
         row("J", 2'd0, SEG_NONE, SEG_NONE),
         row("H", 2'd0, SEG_NONE, SEG_NONE),
         row("O", 2'd0, SEG_NONE, SEG_NONE),
         row("m", 2'd0, SEG_NONE, SEG_NONE)
      };
      foreach (directed_table[i])
         plan_char(directed_table[i]);

      // Mostly letters and spaces, with a share of arbitrary codes.
      for (int i = 0; i < RANDOM_CHARS; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 55)
            plan_char(row(($urandom_range(0, 1) ? mck_pkg::CHAR_LOWER_A
                                                : mck_pkg::CHAR_UPPER_A) +
                          8'($urandom_range(0, 25)), 2'd0, SEG_NONE, SEG_NONE));
         else if (pick < 70)
            plan_char(row(mck_pkg::CHAR_SPACE, 2'd0, SEG_NONE, SEG_NONE));
         else
            plan_char(row(8'($urandom_range(0, 255)), 2'd0, SEG_NONE, SEG_NONE));
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      receiver_on = 1'b1;

      send_chars();
      while (keying_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (keying_expected.size() != 0) begin
         $display("%0d expected segments never arrived.", keying_expected.size());
         error_count++;
      end
      $display("Sent %0d characters (directed edge codes, then random letters, spaces and bytes).",
               chars_sent);
      $display("Compared %0d keying segments, %0d of them flagged invalid; %0d failures.",
               segments_seen, invalid_seen, error_count);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
